@@ design/bba_pkg.sv @@
// Shared types, codes and constants for the bitmap block allocator.
`timescale 1ns / 1ps

package bba_pkg;

    localparam int WORD_BITS         = 32;
    localparam int DEFAULT_MAP_WORDS = 128;
    localparam int FUNC_W            = 2;
    localparam int INDEX_W           = 12;
    localparam int COUNT_W           = 13;
    localparam int STATUS_W          = 2;
    localparam int S_TDATA_W         = 32;
    localparam int M_TDATA_W         = 16;

    localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hffff_ffff;

    localparam logic [FUNC_W-1:0] FUNC_FORMAT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_FORMAT,
        ST_SCAN,
        ST_RELEASE_RD,
        ST_RELEASE_WR,
        ST_RESULT
    } bba_state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_ZERO,
        WR_FORMAT,
        WR_ALLOC,
        WR_RELEASE
    } bba_wr_sel_t;

    typedef struct packed {
        logic                load_item;
        logic                addr_clear;
        logic                addr_inc;
        logic                rd_en;
        logic                rd_release;
        bba_wr_sel_t         wr_sel;
        logic                set_result;
        logic [STATUS_W-1:0] res_status;
        logic                res_grant;
        logic                push;
    } bba_cmd_t;

    typedef struct packed {
        logic              addr_last;
        logic              rd_valid;
        logic              rd_last;
        logic              word_full;
        logic [FUNC_W-1:0] func;
        logic              count_bad;
        logic              index_bad;
        logic              out_free;
    } bba_stat_t;

endpackage

@@ design/bba_datapath.sv @@
// Datapath of the bitmap block allocator: map memory, word counter, item and result registers.
`timescale 1ns / 1ps

module bba_datapath #(
    parameter int MAP_WORDS = bba_pkg::DEFAULT_MAP_WORDS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bba_pkg::bba_cmd_t              cmd,
    output bba_pkg::bba_stat_t             stat,
    input  logic [bba_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bba_pkg::M_TDATA_W-1:0]  m_tdata
);
    import bba_pkg::*;

    localparam int AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CAPACITY = MAP_WORDS * WORD_BITS;
    localparam int CAP_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CAP_W > COUNT_W) ? CAP_W : COUNT_W;
    localparam int WCMP_W   = (AW > COUNT_W - 5) ? AW : COUNT_W - 5;

    logic [WORD_BITS-1:0] mem [MAP_WORDS];

    logic [FUNC_W-1:0]    func_reg;
    logic [INDEX_W-1:0]   bit_index_reg;
    logic [COUNT_W-1:0]   reserve_count_reg;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [AW-1:0]        rd_addr_reg;
    logic                 rd_last_reg;
    logic                 rd_valid_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [STATUS_W-1:0]  res_status_reg;
    logic [INDEX_W-1:0]   res_granted_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [INDEX_W-1:0]   m_granted_reg;

    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        rel_word;
    logic [4:0]           rel_bit;
    logic [WORD_BITS-1:0] low_zero;
    logic [4:0]           low_pos;
    logic [31:0]          grant_full;
    logic [WCMP_W-1:0]    addr_ext, whole_ext;
    logic [WORD_BITS-1:0] format_word;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;

    assign rel_word = AW'(bit_index_reg >> 5);
    assign rel_bit  = bit_index_reg[4:0];
    assign rd_addr  = cmd.rd_release ? rel_word : addr_reg;

    assign low_zero = ~rd_data_reg & (rd_data_reg + WORD_BITS'(1));

    always_comb begin
        low_pos = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            for (int k = 0; k < 5; k++) begin
                if (((i >> k) & 1) == 1) begin
                    low_pos[k] = low_pos[k] | low_zero[i];
                end
            end
        end
    end

    assign grant_full = (32'(rd_addr_reg) << 5) | 32'(low_pos);

    assign addr_ext    = WCMP_W'(addr_reg);
    assign whole_ext   = WCMP_W'(reserve_count_reg[COUNT_W-1:5]);
    always_comb begin
        if (addr_ext < whole_ext) begin
            format_word = FULL_WORD;
        end else if (addr_ext == whole_ext) begin
            format_word = ~(FULL_WORD << reserve_count_reg[4:0]);
        end else begin
            format_word = '0;
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = addr_reg;
        wr_data = '0;
        case (cmd.wr_sel)
            WR_ZERO: begin
                wr_data = '0;
            end
            WR_FORMAT: begin
                wr_data = format_word;
            end
            WR_ALLOC: begin
                wr_addr = rd_addr_reg;
                wr_data = rd_data_reg | low_zero;
            end
            WR_RELEASE: begin
                wr_addr = rd_addr_reg;
                wr_data = rd_data_reg & ~(WORD_BITS'(1) << rel_bit);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
            rd_last_reg <= stat.addr_last;
        end
        if (cmd.load_item) begin
            func_reg          <= s_tdata[FUNC_W-1:0];
            bit_index_reg     <= s_tdata[FUNC_W +: INDEX_W];
            reserve_count_reg <= s_tdata[FUNC_W+INDEX_W +: COUNT_W];
        end
        if (cmd.set_result) begin
            res_status_reg  <= cmd.res_status;
            res_granted_reg <= cmd.res_grant ? grant_full[INDEX_W-1:0] : '0;
        end
        if (cmd.push) begin
            m_status_reg  <= res_status_reg;
            m_granted_reg <= res_granted_reg;
        end
    end

    always_comb begin
        addr_next = addr_reg;
        if (cmd.addr_clear) begin
            addr_next = '0;
        end else if (cmd.addr_inc && !stat.addr_last) begin
            addr_next = addr_reg + AW'(1);
        end
    end

    assign m_valid_next = cmd.push | (m_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            addr_reg     <= addr_next;
            rd_valid_reg <= cmd.rd_en;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign stat.addr_last = (addr_reg == AW'(MAP_WORDS - 1));
    assign stat.rd_valid  = rd_valid_reg;
    assign stat.rd_last   = rd_last_reg;
    assign stat.word_full = (rd_data_reg == FULL_WORD);
    assign stat.func      = func_reg;
    assign stat.count_bad = CMP_W'(reserve_count_reg) > CMP_W'(CAPACITY);
    assign stat.index_bad = CMP_W'(bit_index_reg) >= CMP_W'(CAPACITY);
    assign stat.out_free  = ~m_valid_reg | m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - STATUS_W - INDEX_W){1'b0}}, m_granted_reg, m_status_reg};

endmodule

@@ design/bba_ctrl.sv @@
// Controller state machine of the bitmap block allocator.
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bba_pkg::bba_stat_t  stat,
    output bba_pkg::bba_cmd_t   cmd
);
    import bba_pkg::*;

    bba_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_sel = WR_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.wr_sel   = WR_ZERO;
                cmd.addr_inc = 1'b1;
                if (stat.addr_last) begin
                    cmd.addr_clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item  = 1'b1;
                    cmd.addr_clear = 1'b1;
                    state_next     = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (stat.func == FUNC_FORMAT && !stat.count_bad) begin
                    state_next = ST_FORMAT;
                end else if (stat.func == FUNC_ALLOC) begin
                    state_next = ST_SCAN;
                end else if (stat.func == FUNC_RELEASE && !stat.index_bad) begin
                    state_next = ST_RELEASE_RD;
                end else begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STATUS_RANGE;
                    state_next     = ST_RESULT;
                end
            end
            ST_FORMAT: begin
                cmd.wr_sel   = WR_FORMAT;
                cmd.addr_inc = 1'b1;
                if (stat.addr_last) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STATUS_OK;
                    state_next     = ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (stat.rd_valid && !stat.word_full) begin
                    cmd.wr_sel     = WR_ALLOC;
                    cmd.set_result = 1'b1;
                    cmd.res_status = STATUS_OK;
                    cmd.res_grant  = 1'b1;
                    state_next     = ST_RESULT;
                end else if (stat.rd_valid && stat.rd_last) begin
                    cmd.set_result = 1'b1;
                    cmd.res_status = STATUS_FULL;
                    state_next     = ST_RESULT;
                end else begin
                    cmd.rd_en    = 1'b1;
                    cmd.addr_inc = 1'b1;
                end
            end
            ST_RELEASE_RD: begin
                cmd.rd_en      = 1'b1;
                cmd.rd_release = 1'b1;
                state_next     = ST_RELEASE_WR;
            end
            ST_RELEASE_WR: begin
                cmd.wr_sel     = WR_RELEASE;
                cmd.set_result = 1'b1;
                cmd.res_status = STATUS_OK;
                state_next     = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/bitmap_block_allocator.sv @@
// Top level of the first-fit bitmap block allocator.
//
// The block keeps a free-space map of MAP_WORDS 32-bit words in a single-port
// memory, one bit per block, and serves one request word at a time.
// A request word on the s_ channel selects format, allocate or release; each
// request produces exactly one result word on the m_ channel.
// Format writes every word of the map once; allocate reads the map one word
// per cycle until it finds a word with a clear bit or has read the last word,
// and a rejected request answers without touching the map. After reset the
// block clears the map in a pass over every word, during which s_tready
// stays low. The result sits in an output register, so the next request is
// accepted while a finished result still waits; when the receiver stalls, a
// second finished result waits in the block until the output register frees.
`timescale 1ns / 1ps

module bitmap_block_allocator #(
    parameter int MAP_WORDS = bba_pkg::DEFAULT_MAP_WORDS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0: func (2), bit_index (12), reserve_count (13), zero fill.
    input  logic [bba_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0: status (2), granted_index (12), zero fill.
    output logic [bba_pkg::M_TDATA_W-1:0]  m_tdata
);
    import bba_pkg::*;

    bba_cmd_t  cmd;
    bba_stat_t stat;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_datapath #(
        .MAP_WORDS (MAP_WORDS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // A result is only moved into the output register when it is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> stat.out_free)
        else $error("result pushed over a pending output word");

    // Only one request is in flight at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // Allocation only writes back a word that had a clear bit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_sel == WR_ALLOC) |-> (stat.rd_valid && !stat.word_full))
        else $error("allocation from a full or stale word");

endmodule

@@ tb/sv/bitmap_block_allocator_tb.sv @@
// Self-checking testbench for the first-fit bitmap block allocator.
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;

    import bba_pkg::*;

    localparam int MAP_WORDS   = DEFAULT_MAP_WORDS;
    localparam int CAPACITY    = MAP_WORDS * WORD_BITS;
    localparam int N_DIRECTED  = 27;
    localparam int N_RANDOM    = 700;
    localparam int PAUSE_AT    = 350;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  grant;
    } alloc_result_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [INDEX_W-1:0]  idx;
        logic [COUNT_W-1:0]  count;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  grant;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [WORD_BITS-1:0] used_map [MAP_WORDS];
    alloc_result_t        pending_results [$];
    logic [INDEX_W-1:0]   granted_pool [$];

    int error_count = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    int cycle_count = 0;
    int n_func [4]  = '{0, 0, 0, 0};
    int n_status [4] = '{0, 0, 0, 0};
    int n_checked   = 0;

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b1, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'hfff,  13'h1fff, 1'b0, STATUS_OK,    12'd0},
        '{FUNC_RELEASE, 12'd0,    13'd0,    1'b1, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b0, STATUS_OK,    12'd0},
        '{FUNC_RELEASE, 12'd4095, 13'h1fff, 1'b1, STATUS_OK,    12'd0},
        '{FUNC_UNUSED,  12'hfff,  13'h1fff, 1'b1, STATUS_RANGE, 12'd0},
        '{FUNC_FORMAT,  12'd0,    13'd4097, 1'b1, STATUS_RANGE, 12'd0},
        '{FUNC_FORMAT,  12'hfff,  13'h1fff, 1'b1, STATUS_RANGE, 12'd0},
        '{FUNC_FORMAT,  12'd0,    13'd4096, 1'b1, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b1, STATUS_FULL,  12'd0},
        '{FUNC_RELEASE, 12'd4095, 13'd0,    1'b1, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b1, STATUS_OK,    12'd4095},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b1, STATUS_FULL,  12'd0},
        '{FUNC_RELEASE, 12'h555,  13'd0,    1'b0, STATUS_OK,    12'd0},
        '{FUNC_RELEASE, 12'haaa,  13'd0,    1'b0, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b0, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b0, STATUS_OK,    12'd0},
        '{FUNC_FORMAT,  12'd0,    13'd0,    1'b1, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b1, STATUS_OK,    12'd0},
        '{FUNC_FORMAT,  12'd0,    13'd33,   1'b0, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b0, STATUS_OK,    12'd0},
        '{FUNC_FORMAT,  12'd0,    13'd31,   1'b0, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b0, STATUS_OK,    12'd0},
        '{FUNC_FORMAT,  12'hfff,  13'd4095, 1'b0, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b0, STATUS_OK,    12'd0},
        '{FUNC_ALLOC,   12'd0,    13'd0,    1'b1, STATUS_FULL,  12'd0},
        '{FUNC_UNUSED,  12'd0,    13'd0,    1'b1, STATUS_RANGE, 12'd0}
    };

    bitmap_block_allocator #(
        .MAP_WORDS(MAP_WORDS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic alloc_result_t apply_request(input logic [FUNC_W-1:0] func,
                                                    input logic [INDEX_W-1:0] idx,
                                                    input logic [COUNT_W-1:0] count);
        alloc_result_t res;
        int whole;
        int part;
        int flat;
        bit found;
        res.status = STATUS_RANGE;
        res.grant  = '0;
        found      = 1'b0;
        case (func)
            FUNC_FORMAT: begin
                if (count <= CAPACITY) begin
                    whole = count / WORD_BITS;
                    part  = count % WORD_BITS;
                    for (int w = 0; w < MAP_WORDS; w++) begin
                        if (w < whole)
                            used_map[w] = FULL_WORD;
                        else if (w == whole)
                            used_map[w] = (part == 0) ? '0 : FULL_WORD >> (WORD_BITS - part);
                        else
                            used_map[w] = '0;
                    end
                    res.status = STATUS_OK;
                end
            end
            FUNC_ALLOC: begin
                res.status = STATUS_FULL;
                for (int w = 0; w < MAP_WORDS && !found; w++) begin
                    for (int b = 0; b < WORD_BITS && !found; b++) begin
                        if (!used_map[w][b]) begin
                            used_map[w][b] = 1'b1;
                            flat       = w * WORD_BITS + b;
                            res.grant  = flat[INDEX_W-1:0];
                            res.status = STATUS_OK;
                            found      = 1'b1;
                        end
                    end
                end
            end
            FUNC_RELEASE: begin
                if (idx < CAPACITY) begin
                    used_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
                    res.status = STATUS_OK;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic issue_request(input logic [FUNC_W-1:0] func,
                                 input logic [INDEX_W-1:0] idx,
                                 input logic [COUNT_W-1:0] count,
                                 input logic typed,
                                 input alloc_result_t typed_res);
        alloc_result_t predicted;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - FUNC_W - INDEX_W - COUNT_W){1'b0}}, count, idx, func};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_request(func, idx, count);
        if (func == FUNC_ALLOC && predicted.status == STATUS_OK)
            granted_pool.push_back(predicted.grant);
        pending_results.push_back(typed ? typed_res : predicted);
        n_func[func]++;
    endtask

    always @(posedge aclk) begin
        alloc_result_t got;
        alloc_result_t want;
        cycle_count++;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[STATUS_W-1:0];
            got.grant  = m_tdata[STATUS_W +: INDEX_W];
            n_status[got.status]++;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, got status %0d index %0d",
                         $time, got.status, got.grant);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, got.status);
                    error_count++;
                end
                if (got.grant !== want.grant) begin
                    $display("%0t: granted_index mismatch, expected %0d, got %0d",
                             $time, want.grant, got.grant);
                    error_count++;
                end
            end
        end
        if (cycle_count[12]) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 39) == 0) begin
            stall_left = $urandom_range(5, 30);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 4) != 0);
        end
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] idx;
        logic [COUNT_W-1:0] count;
        int pick;
        int k;
        for (int w = 0; w < MAP_WORDS; w++)
            used_map[w] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            issue_request(directed_rows[i].func, directed_rows[i].idx, directed_rows[i].count,
                          directed_rows[i].typed,
                          '{directed_rows[i].status, directed_rows[i].grant});

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == PAUSE_AT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_results.size() != 0) @(posedge aclk);
                burst_left = 0;
            end
            idx   = INDEX_W'($urandom_range(0, 4095));
            count = COUNT_W'($urandom_range(0, 8191));
            pick  = $urandom_range(0, 99);
            if (pick < 6) begin
                func = FUNC_FORMAT;
                case ($urandom_range(0, 3))
                    0: count = COUNT_W'(CAPACITY - $urandom_range(0, 40));
                    1: count = COUNT_W'($urandom_range(0, 200));
                    2: count = COUNT_W'(CAPACITY);
                    default: begin
                    end
                endcase
            end else if (pick < 9) begin
                func = FUNC_UNUSED;
            end else if (pick < 60) begin
                func = FUNC_ALLOC;
            end else begin
                func = FUNC_RELEASE;
                if (granted_pool.size() != 0 && $urandom_range(0, 9) < 6) begin
                    k   = $urandom_range(0, granted_pool.size() - 1);
                    idx = granted_pool[k];
                    granted_pool.delete(k);
                end
            end
            issue_request(func, idx, count, 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (MAP_WORDS + 20) @(posedge aclk);

        $display("Checked %0d results: %0d format, %0d allocate, %0d release, %0d unused code.",
                 n_checked, n_func[FUNC_FORMAT], n_func[FUNC_ALLOC], n_func[FUNC_RELEASE],
                 n_func[FUNC_UNUSED]);
        $display("Status returned: %0d ok, %0d map full, %0d out of range.",
                 n_status[STATUS_OK], n_status[STATUS_FULL], n_status[STATUS_RANGE]);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
design/bba_pkg.sv
design/bba_datapath.sv
design/bba_ctrl.sv
design/bitmap_block_allocator.sv
tb/sv/bitmap_block_allocator_tb.sv
